// ----- hdl/pce_pkg.sv -----
package pce_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 6;

  localparam logic [WORD_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] TEN      = 64'd10;

  // key kinds
  localparam logic [3:0] KEY_DIGIT  = 4'd0;
  localparam logic [3:0] KEY_OPER   = 4'd1;
  localparam logic [3:0] KEY_EQUALS = 4'd2;
  localparam logic [3:0] KEY_CE     = 4'd3;
  localparam logic [3:0] KEY_AC     = 4'd4;
  localparam logic [3:0] KEY_NEG    = 4'd5;
  localparam logic [3:0] KEY_INV    = 4'd6;
  localparam logic [3:0] KEY_BACK   = 4'd7;
  localparam logic [3:0] KEY_BASE   = 4'd8;
  localparam logic [3:0] KEY_WIDTH  = 4'd9;
  localparam logic [3:0] KEY_SIGN   = 4'd10;
  localparam logic [3:0] KEY_MC     = 4'd11;
  localparam logic [3:0] KEY_MR     = 4'd12;
  localparam logic [3:0] KEY_MADD   = 4'd13;
  localparam logic [3:0] KEY_MSUB   = 4'd14;
  localparam logic [3:0] KEY_MS     = 4'd15;

  // operators
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_MOD  = 4'd5;
  localparam logic [3:0] OP_AND  = 4'd6;
  localparam logic [3:0] OP_OR   = 4'd7;
  localparam logic [3:0] OP_XOR  = 4'd8;
  localparam logic [3:0] OP_SHL  = 4'd9;
  localparam logic [3:0] OP_SHR  = 4'd10;

  // radix codes
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_ACC,
    SRC_QUO,
    SRC_REM
  } src_t;

endpackage

// ----- hdl/programmer_calculator_engine_unit.sv -----
// keys that apply no operator go straight to the done state; an operator or
// equals key that resolves add, sub, logic or shift passes through the apply
// state first; when it resolves mul, div or mod, or for a decimal backspace,
// the 64 steps of the shift-add or restoring divide unit run before apply. a
// zero divisor or the 64-bit minimum over minus one goes straight to apply.
// one item at a time: the next item is taken the cycle after the result item
// has gone. sync reset: decimal, 32 bits, signed, all zero
module programmer_calculator_engine_unit
  import pce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        operation,
  input  logic [3:0]        digit_value,
  input  logic [3:0]        operator_code,
  input  logic [1:0]        base_choice,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] display_value,
  output logic [WORD_W-1:0] accum_value,
  output logic [WORD_W-1:0] answer_value,
  output logic [WORD_W-1:0] memory_value,
  output logic [3:0]        pending_code,
  output logic              entry_active,
  output logic [1:0]        radix_code,
  output logic [1:0]        width_code,
  output logic              signed_on,
  output logic              error_flag
);

  state_t state, state_next;

  logic [WORD_W-1:0] display, display_next;
  logic [WORD_W-1:0] accum, accum_next;
  logic [WORD_W-1:0] answer, answer_next;
  logic [WORD_W-1:0] memory, memory_next;
  logic [3:0]        pending, pending_next;
  logic              entry, entry_next;
  logic [1:0]        radix, radix_next;
  logic [1:0]        width, width_next;
  logic              sgn, sgn_next;
  logic              err, err_next;

  logic [3:0]        key_q, key_q_next;
  logic [3:0]        opc_q, opc_q_next;
  src_t              src, src_next;
  logic              neg_res, neg_res_next;
  logic              divz, divz_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] mp, mp_next;
  logic [WORD_W-1:0] mb, mb_next;
  logic [WORD_W-1:0] dq, dq_next;
  logic [WORD_W-1:0] dr, dr_next;
  logic [WORD_W-1:0] dd, dd_next;

  logic [WORD_W-1:0] m, m_wide;
  logic [WORD_W-1:0] sa, sb, ma, mb_mag, sd, alu, dig_base, dig_val, r;
  logic              big, digit_ok, resolve;
  logic [1:0]        width_inc;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] trial_sub;

  function automatic logic [WORD_W-1:0] width_mask(input logic [1:0] w);
    logic [WORD_W-1:0] res;
    case (w)
      WIDTH_8:  res = 64'h0000_0000_0000_00ff;
      WIDTH_16: res = 64'h0000_0000_0000_ffff;
      WIDTH_32: res = 64'h0000_0000_ffff_ffff;
      default:  res = '1;
    endcase
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] sext(input logic [WORD_W-1:0] v,
                                             input logic [1:0] w);
    logic [WORD_W-1:0] res;
    case (w)
      WIDTH_8:  res = {{56{v[7]}}, v[7:0]};
      WIDTH_16: res = {{48{v[15]}}, v[15:0]};
      WIDTH_32: res = {{32{v[31]}}, v[31:0]};
      default:  res = v;
    endcase
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    m         = width_mask(width);
    width_inc = width + 2'd1;
    m_wide    = width_mask(width_inc);
    sa        = sext(accum, width);
    sb        = sext(display, width);
    sd        = sb;
    ma        = mag(sa);
    mb_mag    = mag(sb);

    // shift count at or past the word width
    case (width)
      WIDTH_8:  big = |display[WORD_W-1:3];
      WIDTH_16: big = |display[WORD_W-1:4];
      WIDTH_32: big = |display[WORD_W-1:5];
      default:  big = |display[WORD_W-1:6];
    endcase

    case (pending)
      OP_ADD: alu = accum + display;
      OP_SUB: alu = accum - display;
      OP_AND: alu = accum & display;
      OP_OR:  alu = accum | display;
      OP_XOR: alu = accum ^ display;
      OP_SHL: alu = big ? '0 : (accum << display[CNT_W-1:0]);
      OP_SHR: begin
        if (sgn) begin
          alu = big ? {WORD_W{sa[WORD_W-1]}}
                    : WORD_W'($signed(sa) >>> display[CNT_W-1:0]);
        end else begin
          alu = big ? '0 : (accum >> display[CNT_W-1:0]);
        end
      end
      default: alu = display;
    endcase

    case (radix)
      RADIX_BIN: digit_ok = (digit_value < 4'd2);
      RADIX_OCT: digit_ok = (digit_value < 4'd8);
      RADIX_DEC: digit_ok = (digit_value < 4'd10);
      default:   digit_ok = 1'b1;
    endcase
    dig_base = entry ? display : '0;
    case (radix)
      RADIX_BIN: dig_val = dig_base << 1;
      RADIX_OCT: dig_val = dig_base << 3;
      RADIX_DEC: dig_val = (dig_base << 3) + (dig_base << 1);
      default:   dig_val = dig_base << 4;
    endcase
    dig_val = (dig_val + WORD_W'(digit_value)) & m;

    resolve = !err && (pending != OP_NONE) &&
              ((operation == KEY_OPER && entry) || operation == KEY_EQUALS);

    // one restoring divide step
    trial     = {dr, dq[WORD_W-1]};
    trial_sub = trial[WORD_W-1:0] - dd;

    case (src)
      SRC_ACC: r = acc;
      SRC_QUO: r = dq;
      default: r = dr;
    endcase
    if (neg_res) r = ~r + 1'b1;
    r = r & m;

    state_next   = state;
    display_next = display;
    accum_next   = accum;
    answer_next  = answer;
    memory_next  = memory;
    pending_next = pending;
    entry_next   = entry;
    radix_next   = radix;
    width_next   = width;
    sgn_next     = sgn;
    err_next     = err;
    key_q_next   = key_q;
    opc_q_next   = opc_q;
    src_next     = src;
    neg_res_next = neg_res;
    divz_next    = divz;
    cnt_next     = cnt;
    acc_next     = acc;
    mp_next      = mp;
    mb_next      = mb;
    dq_next      = dq;
    dr_next      = dr;
    dd_next      = dd;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          key_q_next   = operation;
          opc_q_next   = operator_code;
          divz_next    = 1'b0;
          neg_res_next = 1'b0;
          src_next     = SRC_ACC;
          cnt_next     = '1;
          dr_next      = '0;
          state_next   = ST_DONE;
          if (resolve) begin
            state_next = ST_APPLY;
            case (pending) inside
              OP_MUL: begin
                mp_next    = accum;
                mb_next    = display;
                acc_next   = '0;
                state_next = ST_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (display == '0) begin
                  divz_next = 1'b1;
                end else if (sgn && width == WIDTH_64 && accum == SIGN_BIT &&
                             display == '1) begin
                  acc_next = '0;
                end else begin
                  src_next   = (pending == OP_DIV) ? SRC_QUO : SRC_REM;
                  state_next = ST_DIV;
                  if (sgn) begin
                    dq_next      = ma;
                    dd_next      = mb_mag;
                    neg_res_next = (pending == OP_DIV) ? (sa[WORD_W-1] ^ sb[WORD_W-1])
                                                       : sa[WORD_W-1];
                  end else begin
                    dq_next = accum;
                    dd_next = display;
                  end
                end
              end
              default: acc_next = alu;
            endcase
          end else begin
            case (operation)
              KEY_DIGIT: begin
                if (digit_ok) begin
                  err_next     = 1'b0;
                  entry_next   = 1'b1;
                  display_next = dig_val;
                end
              end
              KEY_OPER: begin
                if (!err) begin
                  accum_next   = display;
                  pending_next = operator_code;
                  entry_next   = 1'b0;
                end
              end
              KEY_EQUALS: begin
                if (!err) begin
                  answer_next = display;
                  entry_next  = 1'b0;
                end
              end
              KEY_CE: begin
                display_next = '0;
                entry_next   = 1'b0;
                err_next     = 1'b0;
              end
              KEY_AC: begin
                display_next = '0;
                accum_next   = '0;
                pending_next = OP_NONE;
                entry_next   = 1'b0;
                err_next     = 1'b0;
              end
              KEY_NEG: if (!err) display_next = (~display + 1'b1) & m;
              KEY_INV: if (!err) display_next = ~display & m;
              KEY_BACK: begin
                if (entry) begin
                  case (radix)
                    RADIX_BIN: display_next = display >> 1;
                    RADIX_OCT: display_next = display >> 3;
                    RADIX_HEX: display_next = display >> 4;
                    default: begin
                      // decimal goes through the divider, by ten
                      dq_next    = sgn ? mag(sd) : display;
                      dd_next    = TEN;
                      src_next   = SRC_QUO;
                      state_next = ST_DIV;
                    end
                  endcase
                end
              end
              KEY_BASE: begin
                radix_next = base_choice;
                entry_next = 1'b0;
              end
              KEY_WIDTH: begin
                width_next   = width_inc;
                display_next = display & m_wide;
                accum_next   = accum & m_wide;
                entry_next   = 1'b0;
              end
              KEY_SIGN: sgn_next = !sgn;
              KEY_MC:   memory_next = '0;
              KEY_MR: begin
                display_next = memory & m;
                entry_next   = 1'b0;
                err_next     = 1'b0;
              end
              KEY_MADD: memory_next = ((memory & m) + display) & m;
              KEY_MSUB: memory_next = ((memory & m) - display) & m;
              default:  memory_next = display & m;
            endcase
          end
        end
      end
      ST_MUL: begin
        if (mb[0]) acc_next = acc + mp;
        mp_next  = mp << 1;
        mb_next  = mb >> 1;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = ST_APPLY;
      end
      ST_DIV: begin
        if (trial >= {1'b0, dd}) begin
          dr_next = trial_sub;
          dq_next = {dq[WORD_W-2:0], 1'b1};
        end else begin
          dr_next = trial[WORD_W-1:0];
          dq_next = {dq[WORD_W-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = ST_DONE;
        if (divz) begin
          err_next     = 1'b1;
          display_next = '0;
          pending_next = OP_NONE;
          entry_next   = 1'b0;
        end else begin
          display_next = r;
          case (key_q)
            KEY_OPER: begin
              accum_next   = r;
              pending_next = opc_q;
              entry_next   = 1'b0;
            end
            KEY_EQUALS: begin
              answer_next  = r;
              pending_next = OP_NONE;
              entry_next   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      display <= '0;
      accum   <= '0;
      answer  <= '0;
      memory  <= '0;
      pending <= OP_NONE;
      entry   <= 1'b0;
      radix   <= RADIX_DEC;
      width   <= WIDTH_32;
      sgn     <= 1'b1;
      err     <= 1'b0;
      divz    <= 1'b0;
    end else begin
      state   <= state_next;
      display <= display_next;
      accum   <= accum_next;
      answer  <= answer_next;
      memory  <= memory_next;
      pending <= pending_next;
      entry   <= entry_next;
      radix   <= radix_next;
      width   <= width_next;
      sgn     <= sgn_next;
      err     <= err_next;
      divz    <= divz_next;
    end
  end

  always_ff @(posedge clk) begin
    key_q   <= key_q_next;
    opc_q   <= opc_q_next;
    src     <= src_next;
    neg_res <= neg_res_next;
    cnt     <= cnt_next;
    acc     <= acc_next;
    mp      <= mp_next;
    mb      <= mb_next;
    dq      <= dq_next;
    dr      <= dr_next;
    dd      <= dd_next;
  end

  assign in_stall      = (state != ST_IDLE);
  assign out_valid     = (state == ST_DONE);
  assign display_value = display;
  assign accum_value   = accum;
  assign answer_value  = answer;
  assign memory_value  = memory;
  assign pending_code  = pending;
  assign entry_active  = entry;
  assign radix_code    = radix;
  assign width_code    = width;
  assign signed_on     = sgn;
  assign error_flag    = err;

endmodule
